// ----- rtl/core/cpmf_pkg.sv -----
// Shared types, field widths, reset values and calendar helpers for the
// cron previous-match finder. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package cpmf_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int TENS_W  = 3;

    // Mask widths
    localparam int TENS_MASK_W  = 6;
    localparam int HOUR_MASK_W  = 24;
    localparam int DAY_MASK_W   = 31;
    localparam int MONTH_MASK_W = 12;

    // Mask reset values: everything allowed
    localparam logic [TENS_MASK_W-1:0]  TENS_MASK_RST  = '1;
    localparam logic [HOUR_MASK_W-1:0]  HOUR_MASK_RST  = '1;
    localparam logic [DAY_MASK_W-1:0]   DAY_MASK_RST   = '1;
    localparam logic [MONTH_MASK_W-1:0] MONTH_MASK_RST = '1;

    // Calendar constants
    localparam int LAST_MONTH = 11;
    localparam int LAST_HOUR  = 23;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;

    // Month length classes; length is MIN_MONTH_LEN plus the class
    localparam int MIN_MONTH_LEN = 28;
    localparam int NUM_LEN_CLS   = 4;
    localparam logic [1:0] LEN_28 = 2'd0;
    localparam logic [1:0] LEN_29 = 2'd1;
    localparam logic [1:0] LEN_30 = 2'd2;
    localparam logic [1:0] LEN_31 = 2'd3;

    // Divisibility by 25 through the inverse of 25 modulo 2**14
    localparam logic [YEAR_W-1:0] INV25      = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    typedef struct packed {
        logic [TENS_MASK_W-1:0]  tens_mask;
        logic [HOUR_MASK_W-1:0]  hour_mask;
        logic [DAY_MASK_W-1:0]   day_mask;
        logic [MONTH_MASK_W-1:0] month_mask;
    } t_masks;

    typedef struct packed {
        logic [YEAR_W-1:0]  now_year;
        logic [MONTH_W-1:0] now_month;
        logic [DAY_W-1:0]   now_day;
        logic [HOUR_W-1:0]  now_hour;
        logic [TENS_W-1:0]  now_tens;
    } t_query;

    typedef struct packed {
        logic               found;
        logic [YEAR_W-1:0]  match_year;
        logic [MONTH_W-1:0] match_month;
        logic [DAY_W-1:0]   match_day;
        logic [HOUR_W-1:0]  match_hour;
        logic [TENS_W-1:0]  match_tens;
    } t_result;

    // Highest set bit of a vector
    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } t_top;

    function automatic t_top f_top(input logic [31:0] v);
        t_top r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = i[4:0];
            end
        end
        return r;
    endfunction

    // Gregorian leap year: divisible by 4 and not by 100, or by 400
    function automatic logic f_is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
        div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [1:0] f_len_cls(input logic leap,
                                             input logic [MONTH_W-1:0] m);
        logic [1:0] c;
        case (m)
            MON_FEB: c = leap ? LEN_29 : LEN_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: c = LEN_30;
            default: c = LEN_31;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cpmf_if.sv -----
// Valid/ready channel interfaces for query items and result items.
// Depends on cpmf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cpmf_in_if import cpmf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  now_year;
    logic [MONTH_W-1:0] now_month;
    logic [DAY_W-1:0]   now_day;
    logic [HOUR_W-1:0]  now_hour;
    logic [TENS_W-1:0]  now_tens;

    modport source(output valid, now_year, now_month, now_day, now_hour, now_tens,
                   input ready);
    modport sink(input valid, now_year, now_month, now_day, now_hour, now_tens,
                 output ready);
endinterface

interface cpmf_out_if import cpmf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [YEAR_W-1:0]  match_year;
    logic [MONTH_W-1:0] match_month;
    logic [DAY_W-1:0]   match_day;
    logic [HOUR_W-1:0]  match_hour;
    logic [TENS_W-1:0]  match_tens;

    modport source(output valid, found, match_year, match_month, match_day,
                   match_hour, match_tens, input ready);
    modport sink(input valid, found, match_year, match_month, match_day,
                 match_hour, match_tens, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cpmf_cfg.sv -----
// APB-style register file holding the four schedule masks.
// Depends on cpmf_pkg for mask widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module cpmf_cfg import cpmf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_masks           o_masks
);

    localparam logic [1:0] REG_TENS  = 2'd0;
    localparam logic [1:0] REG_HOUR  = 2'd1;
    localparam logic [1:0] REG_DAY   = 2'd2;
    localparam logic [1:0] REG_MONTH = 2'd3;

    t_masks     r_masks;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Write the addressed mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks.tens_mask  <= TENS_MASK_RST;
            r_masks.hour_mask  <= HOUR_MASK_RST;
            r_masks.day_mask   <= DAY_MASK_RST;
            r_masks.month_mask <= MONTH_MASK_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TENS:  r_masks.tens_mask  <= pwdata[TENS_MASK_W-1:0];
                REG_HOUR:  r_masks.hour_mask  <= pwdata[HOUR_MASK_W-1:0];
                REG_DAY:   r_masks.day_mask   <= pwdata[DAY_MASK_W-1:0];
                REG_MONTH: r_masks.month_mask <= pwdata[MONTH_MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed mask
    always_comb begin
        case (reg_idx)
            REG_TENS:  prdata = {{(32-TENS_MASK_W){1'b0}}, r_masks.tens_mask};
            REG_HOUR:  prdata = {{(32-HOUR_MASK_W){1'b0}}, r_masks.hour_mask};
            REG_DAY:   prdata = {{(32-DAY_MASK_W){1'b0}}, r_masks.day_mask};
            REG_MONTH: prdata = {{(32-MONTH_MASK_W){1'b0}}, r_masks.month_mask};
            default:   prdata = '0;
        endcase
    end

    assign o_masks = r_masks;

endmodule

`default_nettype wire

// ----- rtl/core/cpmf_search.sv -----
// Combinational search for the latest allowed time not after the query.
// Depends on cpmf_pkg for types, priority encoder and calendar helpers.
`timescale 1ns / 1ps
`default_nettype none

module cpmf_search import cpmf_pkg::*; (
    input  wire t_masks i_masks,
    input  wire t_query i_query,
    output t_result     o_result
);

    t_top                    tens_top, tens_le, hour_top, hour_lt;
    t_top                    day_lt, mon_lt, mon_prev;
    t_top                    dtop [NUM_LEN_CLS];
    logic [TENS_MASK_W-1:0]  tens_lim;
    logic [HOUR_MASK_W-1:0]  hour_lim;
    logic [DAY_MASK_W-1:0]   day_lim;
    logic [DAY_MASK_W-1:0]   day_cls [NUM_LEN_CLS];
    logic [MONTH_MASK_W-1:0] mok_cur, mok_prev, mon_lim;
    logic                    leap_cur, leap_prev, full;
    logic                    hour_at, day_at, mon_at, day_in;
    logic [YEAR_W-1:0]       prev_year;
    logic [1:0]              nm_cls;
    logic [DAY_W-1:0]        nm_len;
    logic [1:0]              cur_cls, prv_cls;

    assign prev_year = i_query.now_year - 14'd1;
    assign leap_cur  = f_is_leap(i_query.now_year);
    assign leap_prev = f_is_leap(prev_year);

    // Last allowed day for each month length
    always_comb begin
        for (int k = 0; k < NUM_LEN_CLS; k++) begin
            for (int i = 0; i < DAY_MASK_W; i++) begin
                day_cls[k][i] = i_masks.day_mask[i] && (i < MIN_MONTH_LEN + k);
            end
            dtop[k] = f_top({1'b0, day_cls[k]});
        end
    end

    // Months that hold at least one allowed day, per year
    always_comb begin
        for (int m = 0; m < MONTH_MASK_W; m++) begin
            mok_cur[m]  = i_masks.month_mask[m]
                          && dtop[f_len_cls(leap_cur, m[MONTH_W-1:0])].found;
            mok_prev[m] = i_masks.month_mask[m]
                          && dtop[f_len_cls(leap_prev, m[MONTH_W-1:0])].found;
            mon_lim[m]  = mok_cur[m] && (m < int'(i_query.now_month));
        end
    end

    assign nm_cls = f_len_cls(leap_cur, i_query.now_month);
    assign nm_len = DAY_W'(MIN_MONTH_LEN) + {3'b0, nm_cls};

    // Bounds below the query in each field, at or below it for the tens slot
    always_comb begin
        mon_at  = 1'b0;
        hour_at = 1'b0;
        day_at  = 1'b0;
        for (int i = 0; i < TENS_MASK_W; i++) begin
            tens_lim[i] = i_masks.tens_mask[i] && (i <= int'(i_query.now_tens));
        end
        for (int i = 0; i < HOUR_MASK_W; i++) begin
            hour_lim[i] = i_masks.hour_mask[i] && (i < int'(i_query.now_hour));
            if (i == int'(i_query.now_hour)) begin
                hour_at = i_masks.hour_mask[i];
            end
        end
        for (int i = 0; i < DAY_MASK_W; i++) begin
            day_lim[i] = i_masks.day_mask[i] && (i + 1 < int'(i_query.now_day))
                         && (i < int'(nm_len));
            if (i + 1 == int'(i_query.now_day)) begin
                day_at = i_masks.day_mask[i];
            end
        end
        for (int m = 0; m < MONTH_MASK_W; m++) begin
            if (m == int'(i_query.now_month)) begin
                mon_at = i_masks.month_mask[m];
            end
        end
    end

    assign tens_top = f_top({{(32-TENS_MASK_W){1'b0}}, i_masks.tens_mask});
    assign tens_le  = f_top({{(32-TENS_MASK_W){1'b0}}, tens_lim});
    assign hour_top = f_top({{(32-HOUR_MASK_W){1'b0}}, i_masks.hour_mask});
    assign hour_lt  = f_top({{(32-HOUR_MASK_W){1'b0}}, hour_lim});
    assign day_lt   = f_top({1'b0, day_lim});
    assign mon_lt   = f_top({{(32-MONTH_MASK_W){1'b0}}, mon_lim});
    assign mon_prev = f_top({{(32-MONTH_MASK_W){1'b0}}, mok_prev});

    assign full    = hour_top.found && tens_top.found;
    assign day_in  = mon_at && (i_query.now_day != '0)
                     && (i_query.now_day <= nm_len) && day_at;
    assign cur_cls = f_len_cls(leap_cur, mon_lt.idx[MONTH_W-1:0]);
    assign prv_cls = f_len_cls(leap_prev, mon_prev.idx[MONTH_W-1:0]);

    // Pick the latest candidate, from the query's own slot downward
    always_comb begin
        o_result = '0;
        if (day_in && hour_at && tens_le.found) begin
            o_result.found       = 1'b1;
            o_result.match_year  = i_query.now_year;
            o_result.match_month = i_query.now_month;
            o_result.match_day   = i_query.now_day;
            o_result.match_hour  = i_query.now_hour;
            o_result.match_tens  = tens_le.idx[TENS_W-1:0];
        end else if (day_in && hour_lt.found && tens_top.found) begin
            o_result.found       = 1'b1;
            o_result.match_year  = i_query.now_year;
            o_result.match_month = i_query.now_month;
            o_result.match_day   = i_query.now_day;
            o_result.match_hour  = hour_lt.idx;
            o_result.match_tens  = tens_top.idx[TENS_W-1:0];
        end else if (mon_at && day_lt.found && full) begin
            o_result.found       = 1'b1;
            o_result.match_year  = i_query.now_year;
            o_result.match_month = i_query.now_month;
            o_result.match_day   = day_lt.idx + 5'd1;
            o_result.match_hour  = hour_top.idx;
            o_result.match_tens  = tens_top.idx[TENS_W-1:0];
        end else if (mon_lt.found && full) begin
            o_result.found       = 1'b1;
            o_result.match_year  = i_query.now_year;
            o_result.match_month = mon_lt.idx[MONTH_W-1:0];
            o_result.match_day   = dtop[cur_cls].idx + 5'd1;
            o_result.match_hour  = hour_top.idx;
            o_result.match_tens  = tens_top.idx[TENS_W-1:0];
        end else if ((i_query.now_year != '0) && mon_prev.found && full) begin
            o_result.found       = 1'b1;
            o_result.match_year  = prev_year;
            o_result.match_month = mon_prev.idx[MONTH_W-1:0];
            o_result.match_day   = dtop[prv_cls].idx + 5'd1;
            o_result.match_hour  = hour_top.idx;
            o_result.match_tens  = tens_top.idx[TENS_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cron_previous_match_finder_top.sv -----
// Top level of the cron previous-match finder: mask registers, query
// register, search logic and result register.
// Depends on cpmf_pkg, cpmf_if, cpmf_cfg and cpmf_search.
//
// Usage:
//   i_in carries query items (year, month, day, hour, ten-minute slot) with
//   valid/ready; o_out carries one result item per query (found flag and the
//   latest allowed time not after the query, all zero when nothing matches).
//   The user must write the four masks over the APB-style port while no
//   item is in flight; the block does not enforce this. pready is always
//   high and reads return the stored mask. Throughput: one item per cycle
//   while the receiver takes results, set by the single query register
//   feeding the combinational search and the result register behind it.
//   Reset (synchronous, active low) empties both stages and sets every mask
//   to all-ones. When the receiver stalls, the result register holds its
//   item, the query register still takes one more item, and i_in.ready drops
//   only once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module cron_previous_match_finder_top import cpmf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    cpmf_in_if.sink          i_in,
    cpmf_out_if.source       o_out
);

    t_masks  masks;
    t_query  r_query;
    t_result r_result;
    t_result search_res;
    logic    r_q_valid, r_r_valid;
    logic    q_advance, in_ready;

    cpmf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_masks (masks)
    );

    cpmf_search u_search (
        .i_masks  (masks),
        .i_query  (r_query),
        .o_result (search_res)
    );

    // Advance the query stage when the result register is free or drains
    assign q_advance  = !r_r_valid || o_out.ready;
    assign in_ready   = !r_q_valid || q_advance;
    assign i_in.ready = in_ready;

    // Hold or load the query register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (in_ready) begin
            r_q_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_query.now_year  <= i_in.now_year;
            r_query.now_month <= i_in.now_month;
            r_query.now_day   <= i_in.now_day;
            r_query.now_hour  <= i_in.now_hour;
            r_query.now_tens  <= i_in.now_tens;
        end
    end

    // Hold or load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (q_advance) begin
            r_r_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_q_valid && q_advance) begin
            r_result <= search_res;
        end
    end

    assign o_out.valid       = r_r_valid;
    assign o_out.found       = r_result.found;
    assign o_out.match_year  = r_result.match_year;
    assign o_out.match_month = r_result.match_month;
    assign o_out.match_day   = r_result.match_day;
    assign o_out.match_hour  = r_result.match_hour;
    assign o_out.match_tens  = r_result.match_tens;

endmodule

`default_nettype wire
